>>> rtl/glpf_pkg.sv
`default_nettype none

package glpf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 4;
  localparam int OUT_IDX_W  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  // position of the next sample within the grid
  typedef struct packed {
    logic row_nz;
    logic row_eq1;
    logic col_nz;
    logic col_gt1;
    logic has_right;
    logic last_row;
    logic last_col;
  } pos_flags_t;

  // hit[0]: (row-1, col), hit[1]: (row, col-1), hit[2]: (row, col)
  typedef struct packed {
    logic [2:0]           hit;
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
  } peak_set_t;

endpackage

`default_nettype wire

>>> rtl/glpf_if.sv
`default_nettype none

interface glpf_sample_if import glpf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface glpf_peak_if import glpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] peak_row;
  logic [OUT_IDX_W-1:0] peak_col;
  logic                 last_of_run;

  modport source (output valid, output peak_row, output peak_col, output last_of_run,
                  input ready);
  modport sink (input valid, input peak_row, input peak_col, input last_of_run,
                output ready);
endinterface

interface glpf_cfg_if import glpf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/glpf_ram.sv
`default_nettype none

module glpf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/glpf_ctrl.sv
`default_nettype none

module glpf_ctrl import glpf_pkg::*; #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024,
  localparam int RW  = $clog2(MAX_ROWS),
  localparam int CW  = $clog2(MAX_COLS),
  localparam int RSW = $clog2(MAX_ROWS + 1),
  localparam int CSW = $clog2(MAX_COLS + 1)
) (
  input  wire logic     clk,
  input  wire logic     rst,
  glpf_cfg_if.sink      cfg,
  input  wire logic     in_fire,
  output logic [RW-1:0] pos_row,
  output logic [CW-1:0] pos_col,
  output pos_flags_t    pos_flags
);

  logic [RSW-1:0] rows;
  logic [CSW-1:0] cols;
  logic           cfg_fire;

  function automatic logic [31:0] clamp_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    logic [31:0] res;
    if (v == '0) begin
      res = 32'd1;
    end else if (32'(v) > maxv) begin
      res = maxv;
    end else begin
      res = 32'(v);
    end
    return res;
  endfunction

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid;

  always_comb begin
    pos_flags.row_nz    = pos_row != '0;
    pos_flags.row_eq1   = 32'(pos_row) == 32'd1;
    pos_flags.col_nz    = pos_col != '0;
    pos_flags.col_gt1   = 32'(pos_col) > 32'd1;
    pos_flags.has_right = 32'(pos_col) + 32'd1 < 32'(cols);
    pos_flags.last_row  = 32'(pos_row) + 32'd1 == 32'(rows);
    pos_flags.last_col  = 32'(pos_col) + 32'd1 == 32'(cols);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows    <= RSW'(1);
      cols    <= CSW'(1);
      pos_row <= '0;
      pos_col <= '0;
    end else if (cfg_fire) begin
      case (cfg.index)
        REG_GRID_ROWS: begin
          rows    <= RSW'(clamp_size(cfg.data, MAX_ROWS));
          pos_row <= '0;
          pos_col <= '0;
        end
        REG_GRID_COLS: begin
          cols    <= CSW'(clamp_size(cfg.data, MAX_COLS));
          pos_row <= '0;
          pos_col <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_fire) begin
      if (pos_flags.last_col) begin
        pos_col <= '0;
        pos_row <= pos_flags.last_row ? '0 : pos_row + RW'(1);
      end else begin
        pos_col <= pos_col + CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/glpf_eval.sv
`default_nettype none

module glpf_eval import glpf_pkg::*; #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 16,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int CW = $clog2(MAX_COLS)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_fire,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic [RW-1:0]       pos_row,
  input  wire logic [CW-1:0]       pos_col,
  input  wire pos_flags_t          pos_flags,
  output logic                     s1_free,
  input  wire logic                ob_ready,
  output logic                     set_valid,
  output peak_set_t                set
);

  typedef logic signed [VALUE_BITS-1:0] val_t;

  logic                    s1_valid;
  val_t                    s1_val;
  logic [RW-1:0]           s1_row;
  logic [CW-1:0]           s1_col;
  pos_flags_t              s1_f;
  logic                    fwd_cur;
  logic                    fwd_nxt;
  val_t                    fwd_newer;
  val_t                    fwd_older;
  val_t                    prev_self;
  val_t                    rs0;
  val_t                    rs1;
  logic [2*VALUE_BITS-1:0] cur_rd;
  logic [VALUE_BITS-1:0]   nxt_rd;
  val_t                    cur_newer;
  val_t                    cur_older;
  val_t                    nxt_newer;
  val_t                    right_a;
  logic [2:0]              hits;
  logic                    s1_adv;
  logic [CW-1:0]           pos_col_p1;
  logic [31:0]             sample_wide;

  function automatic logic peak_test(logic first_row, logic first_col, val_t self,
                                     val_t up, val_t left, val_t right, val_t lower);
    logic res;
    if (first_row && first_col) begin
      res = (self > right) && (self > lower);
    end else begin
      res = (first_row || self >= up) && (first_col || self >= left) &&
            (self >= right) && (self >= lower);
    end
    return res;
  endfunction

  assign pos_col_p1  = pos_col + CW'(1);
  assign sample_wide = {16'b0, in_sample};

  // word at col: {older, newer}
  glpf_ram #(.WIDTH(2 * VALUE_BITS), .DEPTH(MAX_COLS)) u_cur_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata ({cur_newer, s1_val}),
    .re    (in_fire),
    .raddr (pos_col),
    .rdata (cur_rd)
  );

  // copy of newer line, read one column ahead
  glpf_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_COLS)) u_nxt_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (s1_val),
    .re    (in_fire),
    .raddr (pos_col_p1),
    .rdata (nxt_rd)
  );

  always_comb begin
    cur_newer = fwd_cur ? fwd_newer : val_t'(cur_rd[VALUE_BITS-1:0]);
    cur_older = fwd_cur ? fwd_older : val_t'(cur_rd[2*VALUE_BITS-1:VALUE_BITS]);
    nxt_newer = fwd_nxt ? fwd_newer : val_t'(nxt_rd);
    right_a   = s1_f.has_right ? nxt_newer : '0;

    hits[0] = s1_f.row_nz &&
              peak_test(s1_f.row_eq1, !s1_f.col_nz, cur_newer, cur_older, prev_self,
                        right_a, s1_val);
    hits[1] = s1_f.last_row && s1_f.col_nz &&
              peak_test(!s1_f.row_nz, !s1_f.col_gt1, rs0, prev_self, rs1, s1_val, '0);
    hits[2] = s1_f.last_row && s1_f.last_col &&
              peak_test(!s1_f.row_nz, !s1_f.col_nz, s1_val, cur_newer, rs0, '0, '0);

    s1_adv    = s1_valid && ((hits == 3'b000) || ob_ready);
    s1_free   = !s1_valid || s1_adv;
    set_valid = s1_valid && (hits != 3'b000);
    set.hit   = hits;
    set.row   = OUT_IDX_W'(s1_row);
    set.col   = OUT_IDX_W'(s1_col);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      rs0      <= '0;
      rs1      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        rs1 <= rs0;
        rs0 <= s1_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_val    <= val_t'(sample_wide[VALUE_BITS-1:0]);
      s1_row    <= pos_row;
      s1_col    <= pos_col;
      s1_f      <= pos_flags;
      // bypass the line write retiring on this edge
      fwd_cur   <= s1_adv && (s1_col == pos_col);
      fwd_nxt   <= s1_adv && (s1_col == pos_col_p1);
      fwd_newer <= s1_val;
      fwd_older <= cur_newer;
    end
    if (s1_adv) begin
      prev_self <= cur_newer;
    end
  end

endmodule

`default_nettype wire

>>> rtl/glpf_obuf.sv
`default_nettype none

module glpf_obuf import glpf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      set_valid,
  input  wire peak_set_t set,
  output logic           ob_ready,
  glpf_peak_if.source    peaks
);

  logic [2:0]           mask;
  logic [OUT_IDX_W-1:0] row;
  logic [OUT_IDX_W-1:0] col;
  logic                 single;
  logic                 load;

  always_comb begin
    single      = (mask & (mask - 3'd1)) == 3'd0;
    ob_ready    = (mask == 3'd0) || (single && peaks.ready);
    load        = set_valid && ob_ready;
    peaks.valid = mask != 3'd0;
    peaks.last_of_run = single;
    if (mask[0]) begin
      peaks.peak_row = row - OUT_IDX_W'(1);
      peaks.peak_col = col;
    end else if (mask[1]) begin
      peaks.peak_row = row;
      peaks.peak_col = col - OUT_IDX_W'(1);
    end else begin
      peaks.peak_row = row;
      peaks.peak_col = col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 3'd0;
    end else if (load) begin
      mask <= set.hit;
    end else if (peaks.valid && peaks.ready) begin
      mask <= mask & (mask - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row <= set.row;
      col <= set.col;
    end
  end

endmodule

`default_nettype wire

>>> rtl/grid_local_peak_finder.sv
// The deciding sample is registered in the evaluation stage, its peak requests then in the result buffer.
// Throughput: one sample per cycle unless results stall, set by the line buffer RAM (one write, registered read).
// Each sample yields up to three peak requests, drained one per cycle of peaks.ready from the result buffer.
// Reset (rst, synchronous): grid size 1x1, position (0,0), pipeline and result buffer empty.
// Line buffers are not cleared; every entry is written in a grid before it is read.
`default_nettype none

module grid_local_peak_finder import glpf_pkg::*; #(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 1024,
  parameter int VALUE_BITS = 16
) (
  input wire logic    clk,
  input wire logic    rst,
  glpf_cfg_if.sink    cfg,
  glpf_sample_if.sink samples,
  glpf_peak_if.source peaks
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  logic          in_fire;
  logic          s1_free;
  logic          ob_ready;
  logic          set_valid;
  peak_set_t     set;
  logic [RW-1:0] pos_row;
  logic [CW-1:0] pos_col;
  pos_flags_t    pos_flags;

  assign samples.ready = s1_free;
  assign in_fire       = samples.valid && s1_free;

  glpf_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .pos_row   (pos_row),
    .pos_col   (pos_col),
    .pos_flags (pos_flags)
  );

  glpf_eval #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .VALUE_BITS(VALUE_BITS)) u_eval (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_sample (samples.sample),
    .pos_row   (pos_row),
    .pos_col   (pos_col),
    .pos_flags (pos_flags),
    .s1_free   (s1_free),
    .ob_ready  (ob_ready),
    .set_valid (set_valid),
    .set       (set)
  );

  glpf_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .set_valid (set_valid),
    .set       (set),
    .ob_ready  (ob_ready),
    .peaks     (peaks)
  );

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    peaks.valid && peaks.ready && !peaks.last_of_run |=> peaks.valid)
    else $error("result buffer lost a pending peak");

  a_blocked_stage: assert property (@(posedge clk) disable iff (rst)
    set_valid && !ob_ready |-> !samples.ready)
    else $error("sample taken while evaluation stage is blocked");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && (cfg.index == REG_GRID_ROWS || cfg.index == REG_GRID_COLS)
    |=> pos_row == '0 && pos_col == '0)
    else $error("register write did not restart the grid");

endmodule

`default_nettype wire

>>> tb/sv/grid_local_peak_finder_tb.sv
`timescale 1ns / 1ps

module grid_local_peak_finder_tb;
  import glpf_pkg::*;

  localparam int MAX_SPAN      = 1024;
  localparam int RANDOM_ITEMS  = 410;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(15);

  localparam logic signed [SAMPLE_W-1:0] ZERO = '0;

  typedef enum int {SMP_SMALL, SMP_FULL, SMP_EXTREME} sample_mix_e;

  typedef struct {
    logic [OUT_IDX_W-1:0] row;
    logic [OUT_IDX_W-1:0] col;
    logic                 last;
  } peak_t;

  class peak_ledger;
    logic [SIZE_W-1:0]          rows_reg;
    logic [SIZE_W-1:0]          cols_reg;
    logic signed [SAMPLE_W-1:0] up_line [MAX_SPAN];
    logic signed [SAMPLE_W-1:0] cur_line [MAX_SPAN];
    logic signed [SAMPLE_W-1:0] last1;
    logic signed [SAMPLE_W-1:0] last2;
    int                         row_pos;
    int                         col_pos;
    peak_t                      due_peaks[$];
    int                         errors;

    function new();
      foreach (up_line[i]) begin
        up_line[i] = ZERO;
        cur_line[i] = ZERO;
      end
      rows_reg = SIZE_W'(1);
      cols_reg = SIZE_W'(1);
      last1 = ZERO;
      last2 = ZERO;
      row_pos = 0;
      col_pos = 0;
      errors = 0;
    endfunction

    function int span(logic [SIZE_W-1:0] raw, int cap);
      if (raw == 0) return 1;
      if (raw > cap) return cap;
      return int'(raw);
    endfunction

    // corner cell needs a strict win; elsewhere ties count
    function bit beats(int r, int c, logic signed [SAMPLE_W-1:0] self, up, left, right,
                       lower);
      if (r == 0 && c == 0) return self > right && self > lower;
      if (r > 0 && self < up) return 1'b0;
      if (c > 0 && self < left) return 1'b0;
      return self >= right && self >= lower;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      if (idx == REG_GRID_ROWS) rows_reg = val;
      else if (idx == REG_GRID_COLS) cols_reg = val;
      else return;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function void take_sample(logic signed [SAMPLE_W-1:0] s);
      int rows, cols, r, c, n;
      logic signed [SAMPLE_W-1:0] was_cur, up, left, right;
      rows = span(rows_reg, MAX_SPAN);
      cols = span(cols_reg, MAX_SPAN);
      if (row_pos >= rows || col_pos >= cols) begin
        row_pos = 0;
        col_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      n = 0;
      // cell above is decided by this one
      if (r > 0) begin
        left = (c > 0) ? up_line[c-1] : ZERO;
        right = (c + 1 < cols) ? cur_line[c+1] : ZERO;
        if (beats(r - 1, c, cur_line[c], up_line[c], left, right, s)) begin
          due_peaks.push_back(peak_t'{OUT_IDX_W'(r - 1), OUT_IDX_W'(c), 1'b0});
          n++;
        end
      end
      was_cur = cur_line[c];
      up_line[c] = was_cur;
      cur_line[c] = s;
      if (r == rows - 1) begin
        if (c > 0) begin
          up = (r > 0) ? up_line[c-1] : ZERO;
          left = (c > 1) ? last2 : ZERO;
          if (beats(r, c - 1, last1, up, left, s, ZERO)) begin
            due_peaks.push_back(peak_t'{OUT_IDX_W'(r), OUT_IDX_W'(c - 1), 1'b0});
            n++;
          end
        end
        if (c == cols - 1) begin
          up = (r > 0) ? was_cur : ZERO;
          left = (c > 0) ? last1 : ZERO;
          if (beats(r, c, s, up, left, ZERO, ZERO)) begin
            due_peaks.push_back(peak_t'{OUT_IDX_W'(r), OUT_IDX_W'(c), 1'b0});
            n++;
          end
        end
      end
      last2 = last1;
      last1 = s;
      if (c + 1 < cols) begin
        col_pos = c + 1;
      end else begin
        col_pos = 0;
        row_pos = (r + 1 < rows) ? r + 1 : 0;
      end
      if (n > 0) due_peaks[due_peaks.size()-1].last = 1'b1;
    endfunction

    function void check_peak(logic [OUT_IDX_W-1:0] row, logic [OUT_IDX_W-1:0] col,
                             logic last);
      peak_t want;
      if (due_peaks.size() == 0) begin
        errors++;
        $display("%0t: unexpected peak: expected none, got row %0d col %0d last %0b",
                 $time, row, col, last);
        return;
      end
      want = due_peaks.pop_front();
      if (want.row !== row || want.col !== col || want.last !== last) begin
        errors++;
        $display("%0t: peak mismatch: expected row %0d col %0d last %0b, got row %0d col %0d last %0b",
                 $time, want.row, want.col, want.last, row, col, last);
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  bit         steady;
  int         cycle_count = 0;
  peak_ledger book;

  glpf_cfg_if    cfg_ch ();
  glpf_sample_if smp_ch ();
  glpf_peak_if   pk_ch ();

  grid_local_peak_finder dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (smp_ch),
    .peaks   (pk_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_local_peak_finder_tb: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(sample_mix_e mix);
    int v;
    case (mix)
      SMP_SMALL: v = int'($urandom_range(0, 6)) - 3;
      SMP_FULL: v = $urandom();
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // result side: random backpressure
  initial begin
    int gap;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        pk_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pk_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && pk_ch.valid === 1'b1 && pk_ch.ready === 1'b1)
      book.check_peak(pk_ch.peak_row, pk_ch.peak_col, pk_ch.last_of_run);
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_ch.valid <= 1'b1;
    smp_ch.sample <= v;
    @(posedge clk);
    while (smp_ch.ready !== 1'b1) @(posedge clk);
    book.take_sample(v);
  endtask

  task automatic wait_drained();
    smp_ch.valid <= 1'b0;
    while (book.due_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] val);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    book.set_reg(idx, val);
  endtask

  initial begin
    int          sent, budget, kind, i;
    sample_mix_e mix;
    logic [SIZE_W-1:0] rows_raw, cols_raw;
    book = new();
    rst <= 1'b1;
    smp_ch.valid <= 1'b0;
    smp_ch.sample <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_GRID_ROWS;
    cfg_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // 1x1 grid out of reset
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);

    // zero sizes act as 1
    write_reg(REG_GRID_ROWS, SIZE_W'(0));
    write_reg(REG_GRID_COLS, SIZE_W'(0));
    send_sample(16'sd5);
    send_sample(-16'sd5);

    // flat 2x2: ties pass everywhere but the corner
    write_reg(REG_GRID_ROWS, SIZE_W'(2));
    write_reg(REG_GRID_COLS, SIZE_W'(2));
    repeat (4) send_sample(16'sd3);

    // unknown index writes must not restart the grid
    write_reg(REG_GRID_ROWS, SIZE_W'(3));
    write_reg(REG_GRID_COLS, SIZE_W'(3));
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd7);
    write_reg(REG_SPARE_LO, SIZE_W'(1));
    write_reg(REG_SPARE_HI, SIZE_W'(2047));
    send_sample(16'sd0);
    send_sample(16'sd9);
    send_sample(16'sd0);
    send_sample(-16'sd5);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);

    // oversize values clamp
    write_reg(REG_GRID_ROWS, SIZE_W'(2047));
    write_reg(REG_GRID_COLS, SIZE_W'(2));
    send_sample(-16'sd1);
    send_sample(16'sd4);
    send_sample(16'sd2);
    write_reg(REG_GRID_ROWS, SIZE_W'(1));
    write_reg(REG_GRID_COLS, SIZE_W'(1024));
    send_sample(16'sd2);
    send_sample(16'sd2);
    send_sample(16'sd6);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 4) begin
        rows_raw = SIZE_W'($urandom_range(1024, 2047));
        cols_raw = SIZE_W'($urandom_range(1, 3));
        budget = $urandom_range(10, 30);
      end else if (kind < 8) begin
        rows_raw = SIZE_W'($urandom_range(1, 2));
        cols_raw = SIZE_W'($urandom_range(1000, 2047));
        budget = $urandom_range(10, 30);
      end else begin
        rows_raw = SIZE_W'($urandom_range(0, 6));
        cols_raw = SIZE_W'($urandom_range(0, 8));
        budget = book.span(rows_raw, MAX_SPAN) * book.span(cols_raw, MAX_SPAN) *
                 $urandom_range(1, 3);
        if ($urandom_range(0, 6) == 0) budget = $urandom_range(1, budget);
      end
      if ($urandom_range(0, 1)) begin
        write_reg(REG_GRID_ROWS, rows_raw);
        write_reg(REG_GRID_COLS, cols_raw);
      end else begin
        write_reg(REG_GRID_COLS, cols_raw);
        write_reg(REG_GRID_ROWS, rows_raw);
      end
      kind = $urandom_range(0, 9);
      mix = (kind < 7) ? SMP_SMALL : (kind < 9) ? SMP_FULL : SMP_EXTREME;
      for (i = 0; i < budget && sent < RANDOM_ITEMS; i++) begin
        send_sample(draw_sample(mix));
        sent++;
        if ($urandom_range(0, 59) == 0) begin
          if ($urandom_range(0, 1)) wait_drained();
          else write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                         SIZE_W'($urandom_range(0, 2047)));
        end
      end
    end

    steady = 1'b0;
    wait_drained();
    if (book.errors == 0) begin
      $display("grid_local_peak_finder_tb: clean");
    end else begin
      $display("grid_local_peak_finder_tb: errors");
    end
    $finish;
  end

endmodule
